// File: src/wpdfm_pkg.sv
package wpdfm_pkg;

  // Item kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 1'b1;

  // Result scaling and saturation limits
  localparam logic [31:0] MAX32    = 32'hFFFF_FFFF;
  localparam logic [39:0] MAX40    = 40'hFF_FFFF_FFFF;
  localparam logic [16:0] DUTY_ONE = 17'd65536;
  localparam logic [19:0] HZ_MULT  = 20'd1000000;  // 256e6 = 1e6 << 8
  localparam int unsigned PROD_W   = 52;

  // Shared restoring divider
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  typedef struct packed {
    logic        kind;
    logic        pin_level;
    logic [31:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic [39:0] avg_on_time;
    logic [16:0] duty_fraction;
    logic [39:0] frequency;
    logic [31:0] pulses_in_window;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [31:0]          wdata;
  } cfg_item_t;

endpackage

// File: src/wpdfm_if.sv
interface wpdfm_in_if;
  logic                 valid;
  logic                 ready;
  wpdfm_pkg::in_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface wpdfm_out_if;
  logic                 valid;
  logic                 ready;
  wpdfm_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface wpdfm_cfg_if;
  logic                 valid;
  logic                 ready;
  wpdfm_pkg::cfg_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// File: src/windowed_pulse_duty_frequency_meter_top.sv
// Channel   Dir   Payload                                             Handshake
// in_i      in    kind, pin_level, time_us                            valid/ready
// out_o     out   avg_on_time, duty_fraction, frequency, pulses       valid/ready
// cfg_i     in    reg_index (0 active_high, 1 window_length_us), wdata valid/ready
//
// Edge items and the opening tick pass through accept and accumulate; a tick that does
// not close a window also passes through a window check. A closing tick adds up
// to three 64-step passes through one shared restoring divider (average, duty,
// frequency), each preceded by a load state, and then passes through an emit state.
// Reset (rst_ni, async low) clears the accumulators and loads the register defaults.
// in_i.ready is high only while idle; a finished result waits in the output register
// and only a closing tick stalls on it, just before it is loaded.
module windowed_pulse_duty_frequency_meter_top #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wpdfm_in_if.sink     in_i,
  wpdfm_out_if.source  out_o,
  wpdfm_cfg_if.sink    cfg_i
);
  import wpdfm_pkg::*;

  // timestamps are kept at TIME_BITS; compares run at least 32 bits wide
  localparam int unsigned TEXT_W = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int unsigned SUM_W  = TEXT_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_CHECK,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    OP_AVG,
    OP_DUTY,
    OP_FREQ
  } op_e;

  state_e state_q;
  op_e    op_q;

  // configuration
  logic        active_high_q;
  logic [31:0] window_len_q;

  // measurement state
  logic [TIME_BITS-1:0] last_stamp_q;
  logic                 edge_seen_q;
  logic [TIME_BITS-1:0] win_stamp_q;
  logic                 win_started_q;
  logic [31:0]          sum_q;
  logic [31:0]          tally_q;
  logic                 level_q;

  // accepted item
  logic                 kind_q;
  logic                 act_q;
  logic [TIME_BITS-1:0] now_q;

  // divider and results
  logic [DIV_W-1:0]     dividend_q;
  logic [31:0]          divisor_q;
  logic [31:0]          rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [PROD_W-1:0]    prod_q;
  logic [39:0]          avg_q;
  logic [16:0]          duty_q;
  logic [39:0]          freq_q;
  out_item_t            out_item_q;
  logic                 out_valid_q;

  logic [TEXT_W-1:0]    time_ext;
  logic [TIME_BITS-1:0] now_d;
  logic [TIME_BITS-1:0] on_diff;
  logic [SUM_W-1:0]     sum_ext;
  logic [31:0]          sum_d;
  logic [TIME_BITS-1:0] elapsed;
  logic                 win_closed;
  logic                 in_acc;
  logic                 out_free;

  logic [32:0]          rem_sh;
  logic                 rem_ge;
  logic [31:0]          rem_d;
  logic [DIV_W-1:0]     quo_d;
  logic                 op_needed;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  assign in_acc   = in_i.valid && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_o.ready;

  assign time_ext = TEXT_W'(in_i.item.time_us);
  assign now_d    = time_ext[TIME_BITS-1:0];

  // saturating add of the active stretch since the last edge
  assign on_diff = now_q - last_stamp_q;
  assign sum_ext = SUM_W'(sum_q) + SUM_W'(on_diff);
  assign sum_d   = (sum_ext >= SUM_W'(MAX32)) ? MAX32 : sum_ext[31:0];

  assign elapsed    = now_q - win_stamp_q;
  assign win_closed = TEXT_W'(elapsed) >= TEXT_W'(window_len_q);

  // one restoring divide step per cycle
  assign rem_sh = {rem_q, dividend_q[DIV_W-1]};
  assign rem_ge = rem_sh >= {1'b0, divisor_q};
  assign rem_d  = rem_ge ? 32'(rem_sh - {1'b0, divisor_q}) : rem_sh[31:0];
  assign quo_d  = {dividend_q[DIV_W-2:0], rem_ge};

  // zero divisors are settled up front in ST_CHECK
  always_comb begin
    case (op_q)
      OP_AVG:  op_needed = (tally_q != '0);
      OP_DUTY: op_needed = (window_len_q != '0);
      OP_FREQ: op_needed = (tally_q != '0) && (window_len_q != '0);
      default: op_needed = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_high_q <= 1'b1;
      window_len_q  <= 32'd100000;
    end else if (cfg_i.valid) begin
      case (cfg_i.item.reg_index)
        CFG_ACTIVE_HIGH: active_high_q <= cfg_i.item.wdata[0];
        CFG_WINDOW_LEN:  window_len_q  <= cfg_i.item.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= OP_AVG;
      last_stamp_q  <= '0;
      edge_seen_q   <= 1'b0;
      win_stamp_q   <= '0;
      win_started_q <= 1'b0;
      sum_q         <= '0;
      tally_q       <= '0;
      level_q       <= 1'b0;
      kind_q        <= KIND_EDGE;
      act_q         <= 1'b0;
      now_q         <= '0;
      dividend_q    <= '0;
      divisor_q     <= '0;
      rem_q         <= '0;
      cnt_q         <= '0;
      prod_q        <= '0;
      avg_q         <= '0;
      duty_q        <= '0;
      freq_q        <= '0;
      out_item_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // ST_EMIT reloads the output register itself
      if (out_valid_q && out_o.ready && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            kind_q  <= in_i.item.kind;
            act_q   <= ~(in_i.item.pin_level ^ active_high_q);
            now_q   <= now_d;
            state_q <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          state_q <= ST_IDLE;
          if (kind_q == KIND_EDGE) begin
            if (edge_seen_q && level_q) begin
              sum_q <= sum_d;
            end
            if (!level_q && act_q && (tally_q != MAX32)) begin
              tally_q <= tally_q + 32'd1;
            end
            level_q      <= act_q;
            last_stamp_q <= now_q;
            edge_seen_q  <= 1'b1;
          end else if (!win_started_q) begin
            win_stamp_q   <= now_q;
            win_started_q <= 1'b1;
          end else begin
            // close the pulse in progress up to this tick
            if (level_q && edge_seen_q) begin
              sum_q        <= sum_d;
              last_stamp_q <= now_q;
            end
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (win_closed) begin
            prod_q <= PROD_W'(tally_q) * PROD_W'(HZ_MULT);
            avg_q  <= '0;
            duty_q <= ((window_len_q == '0) && (sum_q != '0)) ? DUTY_ONE : '0;
            freq_q <= ((window_len_q == '0) && (tally_q != '0)) ? MAX40 : '0;
            op_q    <= OP_AVG;
            state_q <= ST_LOAD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_LOAD: begin
          if (op_needed) begin
            case (op_q)
              OP_AVG: begin
                dividend_q <= DIV_W'({sum_q, 8'd0});
                divisor_q  <= tally_q;
              end
              OP_DUTY: begin
                dividend_q <= DIV_W'({sum_q, 16'd0});
                divisor_q  <= window_len_q;
              end
              default: begin
                dividend_q <= DIV_W'({prod_q, 8'd0});
                divisor_q  <= window_len_q;
              end
            endcase
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            case (op_q)
              OP_AVG:  op_q <= OP_DUTY;
              OP_DUTY: op_q <= OP_FREQ;
              default: state_q <= ST_EMIT;
            endcase
          end
        end
        ST_DIV: begin
          dividend_q <= quo_d;
          rem_q      <= rem_d;
          cnt_q      <= cnt_q + DIV_CNT_W'(1);
          if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
            state_q <= ST_LOAD;
            case (op_q)
              OP_AVG: begin
                avg_q <= quo_d[39:0];
                op_q  <= OP_DUTY;
              end
              OP_DUTY: begin
                duty_q <= (quo_d > DIV_W'(DUTY_ONE)) ? DUTY_ONE : quo_d[16:0];
                op_q   <= OP_FREQ;
              end
              default: begin
                freq_q  <= (quo_d > DIV_W'(MAX40)) ? MAX40 : quo_d[39:0];
                state_q <= ST_EMIT;
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_item_q.avg_on_time      <= avg_q;
            out_item_q.duty_fraction    <= duty_q;
            out_item_q.frequency        <= freq_q;
            out_item_q.pulses_in_window <= tally_q;
            out_valid_q <= 1'b1;
            win_stamp_q <= now_q;
            sum_q       <= '0;
            tally_q     <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
